@@ rtl/assert_macros.svh @@
// assertion macros shared by the packer rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define DBP_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dbp assertion failed");
// condition must never be seen out of reset
`define DBP_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("dbp forbidden condition seen");
`else
`define DBP_ASSERT(name, clk, rst, prop)
`define DBP_NEVER(name, clk, rst, cond)
`endif
`endif

@@ rtl/dbp_pkg.sv @@
// shared types, constants and helpers for the depth block delta packer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dbp_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLES = 2'd0;
  localparam logic [1:0] REG_BLOCKS  = 2'd1;

  localparam logic [15:0] RANGE_LIMIT = 16'd32767;
  localparam logic [4:0]  HDR_BITS    = 5'd20;
  localparam logic [6:0]  WORD_BITS   = 7'd64;

  // one finished block waiting to be packed
  typedef struct packed {
    logic        bank;
    logic [15:0] minimum;
    logic [15:0] range;
    logic        final_block;
  } desc_t;

  // bank handed back to the front once packed
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // one result beat
  typedef struct packed {
    logic        strobe;
    logic [63:0] word;
    logic [6:0]  bits;
    logic        clamped;
    logic        final_word;
    logic        last_of_run;
  } res_t;

  // bit length of a value below 2^15
  function automatic logic [3:0] bit_len15(input logic [14:0] v);
    logic [3:0] w;
    w = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (v[i]) w = 4'(i + 1);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dbp_queue.sv @@
// two-entry queue of block descriptors between front and back
// depends on dbp_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dbp_queue import dbp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t din,
  input  logic  pop,
  output desc_t dout,
  output logic  nonempty
);

  desc_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  assign dout     = q[rd_ptr];
  assign nonempty = (count != 2'd0);

  // only two banks exist, so a third pending block cannot happen
  `DBP_NEVER(a_queue_overflow, clk, rst, push && !pop && count == 2'd2)

endmodule

`default_nettype wire

@@ rtl/dbp_front.sv @@
// sample intake: config registers, block min/max tracking, bank fill
// depends on dbp_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dbp_front import dbp_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = 256,
  parameter int MAX_BLOCKS = 4096,
  localparam int PW = $clog2(MAX_BLOCK_SAMPLES + 1),
  localparam int AW = (MAX_BLOCK_SAMPLES > 1) ? $clog2(MAX_BLOCK_SAMPLES) : 1,
  localparam int BW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [15:0]   depth_sample,
  output logic          busy,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_data,
  output logic          restart,
  output logic [PW-1:0] n_eff,
  output logic          mem_we,
  output logic [AW:0]   mem_waddr,
  output logic [15:0]   mem_wdata,
  output logic          push,
  output desc_t         desc,
  input  rel_t          bank_free
);

  logic [8:0]    samples_per_block;
  logic [12:0]   blocks_per_section;
  logic [PW-1:0] sample_pos;
  logic [BW-1:0] block_pos;
  logic [BW-1:0] b_eff;
  logic [15:0]   run_min;
  logic [15:0]   run_max;
  logic          fill_bank;
  logic [1:0]    bank_busy;
  logic [1:0]    bank_busy_next;
  logic          accept;
  logic          blk_end;
  logic          sec_end;
  logic [15:0]   s_min;
  logic [15:0]   s_max;

  // out-of-range register values act as the nearest legal value
  always_comb begin
    if (samples_per_block == 9'd0) n_eff = PW'(1);
    else if (32'(samples_per_block) > MAX_BLOCK_SAMPLES) n_eff = PW'(MAX_BLOCK_SAMPLES);
    else n_eff = PW'(samples_per_block);
    if (blocks_per_section == 13'd0) b_eff = BW'(1);
    else if (32'(blocks_per_section) > MAX_BLOCKS) b_eff = BW'(MAX_BLOCKS);
    else b_eff = BW'(blocks_per_section);
  end

  assign busy    = bank_busy[fill_bank];
  assign accept  = start && !busy;
  assign s_min   = (depth_sample < run_min) ? depth_sample : run_min;
  assign s_max   = (depth_sample > run_max) ? depth_sample : run_max;
  assign blk_end = accept && ((PW+1)'(sample_pos) + (PW+1)'(1) >= (PW+1)'(n_eff));
  assign sec_end = blk_end && ((BW+1)'(block_pos) + (BW+1)'(1) >= (BW+1)'(b_eff));
  assign restart = cfg_write && (cfg_index == REG_SAMPLES || cfg_index == REG_BLOCKS);

  assign mem_we    = accept;
  assign mem_waddr = {fill_bank, sample_pos[AW-1:0]};
  assign mem_wdata = depth_sample;

  assign push             = blk_end;
  assign desc.bank        = fill_bank;
  assign desc.minimum     = s_min;
  assign desc.range       = s_max - s_min;
  assign desc.final_block = sec_end;

  // bank released by the back and bank claimed by a finished block
  always_comb begin
    bank_busy_next = bank_busy;
    if (bank_free.valid) bank_busy_next[bank_free.bank] = 1'b0;
    if (blk_end) bank_busy_next[fill_bank] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_block  <= 9'd256;
      blocks_per_section <= 13'd4096;
      sample_pos         <= '0;
      block_pos          <= '0;
      run_min            <= 16'hFFFF;
      run_max            <= 16'h0000;
      fill_bank          <= 1'b0;
      bank_busy          <= 2'b00;
    end else begin
      bank_busy <= bank_busy_next;
      if (blk_end) fill_bank <= ~fill_bank;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SAMPLES: samples_per_block  <= cfg_data[8:0];
          REG_BLOCKS:  blocks_per_section <= cfg_data;
          default: ;
        endcase
      end
      // a write to either config register drops the partial block and starts a new section
      if (restart) begin
        sample_pos <= '0;
        block_pos  <= '0;
        run_min    <= 16'hFFFF;
        run_max    <= 16'h0000;
      end else if (accept) begin
        if (blk_end) begin
          sample_pos <= '0;
          run_min    <= 16'hFFFF;
          run_max    <= 16'h0000;
          block_pos  <= sec_end ? '0 : block_pos + BW'(1);
        end else begin
          sample_pos <= sample_pos + PW'(1);
          run_min    <= s_min;
          run_max    <= s_max;
        end
      end
    end
  end

  // a finished block's bank stays owned by the back until it is packed
  `DBP_ASSERT(a_bank_claimed, clk, rst, blk_end |=> bank_busy[!fill_bank])

endmodule

`default_nettype wire

@@ rtl/dbp_back.sv @@
// block packer: sample bank memory, bit accumulator and word output
// depends on dbp_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dbp_back import dbp_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = 256,
  localparam int PW = $clog2(MAX_BLOCK_SAMPLES + 1),
  localparam int AW = (MAX_BLOCK_SAMPLES > 1) ? $clog2(MAX_BLOCK_SAMPLES) : 1,
  localparam int DEPTH = 2 * (2 ** AW)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic [PW-1:0] n_eff,
  input  logic          mem_we,
  input  logic [AW:0]   mem_waddr,
  input  logic [15:0]   mem_wdata,
  input  desc_t         head,
  input  logic          head_valid,
  output logic          pop,
  output rel_t          bank_free,
  output res_t          result
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HEAD  = 3'd1;
  localparam logic [2:0] ST_SAMP  = 3'd2;
  localparam logic [2:0] ST_END   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic          job_bank;
  logic          job_clamp;
  logic          job_final;
  logic [15:0]   job_min;
  logic [3:0]    job_width;
  logic [PW-1:0] idx;
  logic [63:0]   acc;
  logic [6:0]    cnt;
  logic [63:0]   hold_word;
  logic          hold_valid;
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rdata;
  logic [PW-1:0] rd_idx;
  logic [AW:0]   raddr;
  logic          pop_clamp;
  logic [14:0]   pop_range;
  logic [15:0]   delta;
  logic          app_en;
  logic [19:0]   app_val;
  logic [4:0]    app_n;
  logic [83:0]   wide;
  logic [7:0]    sum;
  logic          emit;
  res_t          res_next;

  // sample banks, one per block in flight
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[raddr];
  end

  assign rd_idx = (state == ST_HEAD) ? '0 : idx + PW'(1);
  assign raddr  = {job_bank, rd_idx[AW-1:0]};

  assign pop_clamp = head.range > RANGE_LIMIT;
  assign pop_range = pop_clamp ? RANGE_LIMIT[14:0] : head.range[14:0];

  always_comb begin
    pop        = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          state_next = ST_HEAD;
        end
      end
      ST_HEAD:  state_next = (job_width == 4'd0) ? ST_END : ST_SAMP;
      ST_SAMP:  if (idx == n_eff - PW'(1)) state_next = ST_END;
      ST_END:   state_next = (job_final && cnt != 7'd0) ? ST_FLUSH : ST_IDLE;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign bank_free.valid = (state == ST_END && state_next == ST_IDLE) || state == ST_FLUSH;
  assign bank_free.bank  = job_bank;

  // append one field to the bit stream
  always_comb begin
    delta = rdata - job_min;
    if (job_clamp && delta > RANGE_LIMIT) delta = RANGE_LIMIT;
    delta   = delta & ((16'd1 << job_width) - 16'd1);
    app_en  = (state == ST_HEAD) || (state == ST_SAMP);
    app_val = (state == ST_HEAD) ? {job_min, job_width} : {4'b0000, delta};
    app_n   = (state == ST_HEAD) ? HDR_BITS : {1'b0, job_width};
    wide    = {20'b0, acc} | ({64'b0, app_val} << cnt);
    sum     = {1'b0, cnt} + {3'b000, app_n};
    emit    = app_en && (sum >= {1'b0, WORD_BITS});
  end

  // one full word is held back until it is known whether it ends the run
  always_comb begin
    res_next         = '0;
    res_next.clamped = job_clamp;
    if (emit && hold_valid) begin
      res_next.strobe = 1'b1;
      res_next.word   = hold_word;
      res_next.bits   = WORD_BITS;
    end else if (state == ST_END && hold_valid) begin
      res_next.strobe      = 1'b1;
      res_next.word        = hold_word;
      res_next.bits        = WORD_BITS;
      res_next.final_word  = job_final && cnt == 7'd0;
      res_next.last_of_run = !(job_final && cnt != 7'd0);
    end else if (state == ST_FLUSH) begin
      res_next.strobe      = 1'b1;
      res_next.word        = acc;
      res_next.bits        = cnt;
      res_next.final_word  = 1'b1;
      res_next.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_bank  <= head.bank;
      job_min   <= head.minimum;
      job_clamp <= pop_clamp;
      job_width <= bit_len15(pop_range);
      job_final <= head.final_block;
    end
    if (pop) idx <= '0;
    else if (state == ST_SAMP) idx <= idx + PW'(1);
    if (emit) hold_word <= wide[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      acc        <= 64'd0;
      cnt        <= 7'd0;
      hold_valid <= 1'b0;
      result     <= '0;
    end else begin
      state  <= state_next;
      result <= res_next;
      if (app_en) begin
        if (emit) begin
          acc        <= {44'b0, wide[83:64]};
          cnt        <= 7'(sum - {1'b0, WORD_BITS});
          hold_valid <= 1'b1;
        end else begin
          acc <= wide[63:0];
          cnt <= sum[6:0];
        end
      end
      if (state == ST_END) hold_valid <= 1'b0;
      if (state == ST_FLUSH) begin
        acc <= 64'd0;
        cnt <= 7'd0;
      end
      if (restart) begin
        acc        <= 64'd0;
        cnt        <= 7'd0;
        hold_valid <= 1'b0;
      end
    end
  end

  `DBP_ASSERT(a_final_is_last, clk, rst, result.strobe && result.final_word |-> result.last_of_run)
  `DBP_ASSERT(a_short_word_final, clk, rst, result.strobe && result.bits != WORD_BITS |-> result.final_word)
  `DBP_ASSERT(a_flush_has_bits, clk, rst, state == ST_FLUSH |-> cnt != 7'd0 && !hold_valid)

endmodule

`default_nettype wire

@@ rtl/depth_block_delta_packer.sv @@
// top level of the depth block delta packer
// depends on dbp_pkg, dbp_front, dbp_queue, dbp_back
//
// usage: one 16-bit depth sample is taken on each edge with start high and busy
// low. samples group into blocks; each finished block is packed as a 4-bit delta
// width, the 16-bit block minimum and one delta per sample, lsb first, into a
// continuous stream cut into 64-bit words. each word leaves on result_strobe for
// one cycle; the receiver cannot stall it. the last beat caused by one sample has
// last_of_run set, the beat that closes a section has final_word set.
// config: cfg_valid/cfg_index/cfg_data, always ready; a write to either register
// restarts the section. write only while the block is idle.
// flow: the front takes one sample per cycle while busy is low, into one of two
// sample banks; the back packs one sample per cycle, stepping through header, sample
// (skipped when all samples are equal), end and, when a section ends on a partial
// word, flush states. busy rises when the front wants a bank the back still reads.
// each full word is held back until the next word boundary or the block end.
// reset: synchronous; registers return to 256 samples and 4096 blocks, stream empty.
`timescale 1ns / 1ps
`default_nettype none

module depth_block_delta_packer import dbp_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = 256,
  parameter int MAX_BLOCKS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // sample channel
  input  logic        start,
  output logic        busy,
  input  logic [15:0] depth_sample,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // result beats
  output logic        result_strobe,
  output logic [63:0] packed_word,
  output logic [6:0]  valid_bits,
  output logic        block_clamped,
  output logic        final_word,
  output logic        last_of_run
);

  localparam int PW = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int AW = (MAX_BLOCK_SAMPLES > 1) ? $clog2(MAX_BLOCK_SAMPLES) : 1;

  logic          restart;
  logic [PW-1:0] n_eff;
  logic          mem_we;
  logic [AW:0]   mem_waddr;
  logic [15:0]   mem_wdata;
  logic          push;
  desc_t         desc;
  desc_t         head;
  logic          head_valid;
  logic          pop;
  rel_t          bank_free;
  res_t          result;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  // front: sample intake, min/max per block, config registers
  dbp_front #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .depth_sample(depth_sample),
    .busy(busy),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .restart(restart),
    .n_eff(n_eff),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .push(push),
    .desc(desc),
    .bank_free(bank_free)
  );

  // finished blocks waiting for the packer
  dbp_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din(desc),
    .pop(pop),
    .dout(head),
    .nonempty(head_valid)
  );

  // back: reads a bank and packs it into 64-bit words
  dbp_back #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .restart(restart),
    .n_eff(n_eff),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .head(head),
    .head_valid(head_valid),
    .pop(pop),
    .bank_free(bank_free),
    .result(result)
  );

  // result beat straight from the back's output register
  assign result_strobe = result.strobe;
  assign packed_word   = result.word;
  assign valid_bits    = result.bits;
  assign block_clamped = result.clamped;
  assign final_word    = result.final_word;
  assign last_of_run   = result.last_of_run;

endmodule

`default_nettype wire

@@ tb/sv/depth_block_delta_packer_checker.sv @@
`timescale 1ns / 1ps
// checker for the depth block delta packer: tracks sample, register and result beats,
// predicts each packed word and compares it field by field
// depends on dbp_pkg for register indexes and stream constants
module depth_block_delta_packer_checker import dbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] depth_sample,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        result_strobe,
  input  logic [63:0] packed_word,
  input  logic [6:0]  valid_bits,
  input  logic        block_clamped,
  input  logic        final_word,
  input  logic        last_of_run,
  output int          mismatches,
  output int          words_waiting,
  output int          words_checked
);

  localparam int MAX_SAMPLES     = 256;
  localparam int MAX_BLOCK_COUNT = 4096;

  typedef struct {
    logic [63:0] word;
    logic [6:0]  bits;
    logic        clamped;
    logic        final_w;
    logic        last;
  } word_beat_t;

  word_beat_t  pending_words[$];
  word_beat_t  step_words[$];

  logic [15:0] block_samples [MAX_SAMPLES];
  logic [8:0]  samples_reg;
  logic [12:0] blocks_reg;
  int          sample_idx;
  int          block_idx;
  logic [15:0] block_min;
  logic [15:0] block_max;
  logic [63:0] stream_bits;
  int          stream_fill;
  logic        block_clamp_flag;
  int          fail_count = 0;
  int          beat_count = 0;

  function automatic int samples_in_block();
    if (samples_reg == 0) return 1;
    if (samples_reg > MAX_SAMPLES) return MAX_SAMPLES;
    return int'(samples_reg);
  endfunction

  function automatic int blocks_in_section();
    if (blocks_reg == 0) return 1;
    if (blocks_reg > MAX_BLOCK_COUNT) return MAX_BLOCK_COUNT;
    return int'(blocks_reg);
  endfunction

  function automatic void restart_section();
    sample_idx  = 0;
    block_idx   = 0;
    block_min   = '1;
    block_max   = '0;
    stream_bits = '0;
    stream_fill = 0;
  endfunction

  function automatic void push_word(input logic [63:0] word, input logic [6:0] bits,
                                    input logic is_final);
    word_beat_t beat;
    beat.word    = word;
    beat.bits    = bits;
    beat.clamped = block_clamp_flag;
    beat.final_w = is_final;
    beat.last    = 1'b0;
    step_words   = {step_words, beat};
  endfunction

  // lsb-first append of up to 16 bits, cutting off every full word
  function automatic void stream_append(input logic [15:0] value, input int n);
    logic [63:0] chunk;
    if (n == 0) return;
    chunk = 64'(value) & ((64'd1 << n) - 64'd1);
    stream_bits |= chunk << stream_fill;
    if (stream_fill + n >= 64) begin
      push_word(stream_bits, WORD_BITS, 1'b0);
      stream_bits = chunk >> (64 - stream_fill);
      stream_fill = stream_fill + n - 64;
    end else begin
      stream_fill += n;
    end
  endfunction

  function automatic int delta_width(input logic [15:0] span);
    int w;
    w = 0;
    while (span != 0) begin
      span = span >> 1;
      w++;
    end
    return w;
  endfunction

  function automatic void pack_block(input int count);
    logic [15:0] span;
    logic [15:0] delta;
    int          width;
    span = block_max - block_min;
    block_clamp_flag = span > RANGE_LIMIT;
    if (block_clamp_flag) span = RANGE_LIMIT;
    width = delta_width(span);
    stream_append(16'(width), 4);
    stream_append(block_min, 16);
    for (int i = 0; i < count; i++) begin
      delta = block_samples[i] - block_min;
      if (block_clamp_flag && delta > RANGE_LIMIT) delta = RANGE_LIMIT;
      stream_append(delta, width);
    end
  endfunction

  // one accepted sample: collect it, pack a finished block, close the section
  function automatic void take_sample(input logic [15:0] s);
    int n;
    n = samples_in_block();
    step_words.delete();
    block_clamp_flag = 1'b0;
    if (sample_idx >= n) sample_idx = 0;
    block_samples[sample_idx] = s;
    if (s < block_min) block_min = s;
    if (s > block_max) block_max = s;
    sample_idx++;
    if (sample_idx >= n) begin
      pack_block(n);
      sample_idx = 0;
      block_min  = '1;
      block_max  = '0;
      block_idx++;
      if (block_idx >= blocks_in_section()) begin
        if (stream_fill > 0) begin
          push_word(stream_bits, 7'(stream_fill), 1'b1);
        end else if (step_words.size() > 0) begin
          step_words[step_words.size() - 1].final_w = 1'b1;
        end
        restart_section();
      end
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    pending_words = {pending_words, step_words};
  endfunction

  function automatic void write_register(input logic [1:0] index, input logic [12:0] value);
    if (index == REG_SAMPLES) begin
      samples_reg = value[8:0];
      restart_section();
    end else if (index == REG_BLOCKS) begin
      blocks_reg = value;
      restart_section();
    end
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ERROR %s", $time, what);
  endtask

  task automatic check_beat();
    word_beat_t want;
    beat_count++;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("word beat %0d arrived with nothing outstanding", beat_count));
    end else begin
      want = pending_words.pop_front();
      if (packed_word !== want.word)
        report_mismatch($sformatf("beat %0d packed_word: want %h got %h",
                                  beat_count, want.word, packed_word));
      if (valid_bits !== want.bits)
        report_mismatch($sformatf("beat %0d valid_bits: want %0d got %0d",
                                  beat_count, want.bits, valid_bits));
      if (block_clamped !== want.clamped)
        report_mismatch($sformatf("beat %0d block_clamped: want %b got %b",
                                  beat_count, want.clamped, block_clamped));
      if (final_word !== want.final_w)
        report_mismatch($sformatf("beat %0d final_word: want %b got %b",
                                  beat_count, want.final_w, final_word));
      if (last_of_run !== want.last)
        report_mismatch($sformatf("beat %0d last_of_run: want %b got %b",
                                  beat_count, want.last, last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      samples_reg = 9'd256;
      blocks_reg  = 13'd4096;
      restart_section();
      pending_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (start && !busy) take_sample(depth_sample);
      if (result_strobe) check_beat();
    end
    words_waiting <= pending_words.size();
    mismatches    <= fail_count;
    words_checked <= beat_count;
  end

endmodule

@@ tb/sv/depth_block_delta_packer_tb.sv @@
`timescale 1ns / 1ps
// top of the depth block delta packer testbench: clock, reset, sample and register
// stimulus, verdict; prediction and comparison live in depth_block_delta_packer_checker
// depends on dbp_pkg, depth_block_delta_packer and depth_block_delta_packer_checker
module depth_block_delta_packer_tb;
  import dbp_pkg::*;

  // indexes past the register list, writes there must change nothing
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  // watchdog limit, ample for the slowest run
  localparam int CYCLE_LIMIT  = 200000;
  // extra wait after the predicted words are out, covers the drain of a full 256-sample block
  localparam int DRAIN_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] depth_sample;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        result_strobe;
  logic [63:0] packed_word;
  logic [6:0]  valid_bits;
  logic        block_clamped;
  logic        final_word;
  logic        last_of_run;

  int mismatches;
  int words_waiting;
  int words_checked;
  int cycle_count   = 0;
  int samples_sent  = 0;
  int writes_done   = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  depth_block_delta_packer DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .depth_sample  (depth_sample),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .packed_word   (packed_word),
    .valid_bits    (valid_bits),
    .block_clamped (block_clamped),
    .final_word    (final_word),
    .last_of_run   (last_of_run)
  );

  depth_block_delta_packer_checker packer_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .depth_sample  (depth_sample),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .packed_word   (packed_word),
    .valid_bits    (valid_bits),
    .block_clamped (block_clamped),
    .final_word    (final_word),
    .last_of_run   (last_of_run),
    .mismatches    (mismatches),
    .words_waiting (words_waiting),
    .words_checked (words_checked)
  );

  // watchdog, a hung handshake or a missing word ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d words outstanding",
               cycle_count, words_waiting);
      $display("Mismatches found");
      $finish;
    end
  end

  // one sample beat; idle_pct is the chance per cycle of holding start low first
  // start stays high across back-to-back beats, only one assignment per falling edge
  task automatic send_depth(input logic [15:0] value, input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      @(negedge clk);
      start        <= 1'b0;
      depth_sample <= 16'($urandom);
    end
    @(negedge clk);
    start        <= 1'b1;
    depth_sample <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    samples_sent++;
  endtask

  // wait until every predicted word has come out
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    do @(negedge clk); while (words_waiting != 0);
    // a partial block may still be moving through the pipe without a word to show
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_register(input logic [1:0] index, input logic [12:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    writes_done++;
  endtask

  // random samples, one base and spread per block so every delta width turns up,
  // a full 16-bit spread can give clamped blocks, a zero spread can give flat blocks
  task automatic run_random(input int block_len, input int items, input int idle_pct);
    int          spread;
    int          pick;
    logic [15:0] base;
    logic [15:0] value;
    spread = 0;
    base   = '0;
    for (int i = 0; i < items; i++) begin
      if (i % block_len == 0) begin
        spread = $urandom_range(16);
        base   = 16'($urandom);
      end
      pick  = $urandom_range(19);
      value = base + 16'($urandom & ((32'd1 << spread) - 32'd1));
      if (pick == 0) value = '0;
      else if (pick == 1) value = '1;
      send_depth(value, idle_pct);
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    depth_sample = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // two samples per block, every block closes its section with a flush word
    write_register(REG_SAMPLES, 13'd2);
    write_register(REG_BLOCKS, 13'd1);
    // flat block, zero delta width
    send_depth(16'h0000, 0);
    send_depth(16'h0000, 0);
    // widest range, clamped
    send_depth(16'h0000, 0);
    send_depth(16'hFFFF, 0);
    // flat at the top of the sample range
    send_depth(16'hFFFF, 0);
    send_depth(16'hFFFF, 0);
    // range right at the clamp limit, not clamped
    send_depth(16'h1234, 0);
    send_depth(16'h1234 + 16'd32767, 0);
    // range one past the limit, larger sample first
    send_depth(16'h8000, 0);
    send_depth(16'h0000, 0);
    send_depth(16'h5555, 0);
    send_depth(16'hAAAA, 0);

    // 20 header bits + 4 deltas of 11 bits fill exactly one word: no flush,
    // final_word rides on the full word instead
    write_register(REG_SAMPLES, 13'd4);
    send_depth(16'd100, 0);
    send_depth(16'd1600, 0);
    send_depth(16'd900, 0);
    send_depth(16'd1100, 0);

    // writes past the register list leave the block size and stream alone
    write_register(REG_SPARE_A, 13'h0AAA);
    write_register(REG_SPARE_B, 13'h1FFF);
    send_depth(16'hFFFF, 0);
    send_depth(16'h0001, 0);
    send_depth(16'h7FFF, 0);
    send_depth(16'h8000, 0);

    // only bit 9 set, so the block size field reads zero and acts as one sample;
    // three 20-bit blocks then flush 60 bits
    write_register(REG_SAMPLES, 13'h0200);
    write_register(REG_BLOCKS, 13'd3);
    send_depth(16'h0F0F, 0);
    send_depth(16'hF0F0, 0);
    send_depth(16'h0000, 0);

    // sender idles now and then
    write_register(REG_SAMPLES, 13'd3);
    write_register(REG_BLOCKS, 13'd2);
    run_random(3, 30, 7);
    // zero blocks per section acts as one
    write_register(REG_SAMPLES, 13'd8);
    write_register(REG_BLOCKS, 13'd0);
    run_random(8, 32, 7);

    // sender idles most of the time
    write_register(REG_SAMPLES, 13'd1);
    write_register(REG_BLOCKS, 13'd5);
    run_random(1, 25, 72);
    // section count beyond the maximum, clipped to 4096
    write_register(REG_SAMPLES, 13'd16);
    write_register(REG_BLOCKS, 13'h1FFF);
    run_random(16, 32, 72);

    // back to back, busy does all the throttling
    write_register(REG_SAMPLES, 13'd5);
    write_register(REG_BLOCKS, 13'd3);
    run_random(5, 30, 0);

    wait_drained();
    $display("sent %0d depth samples and %0d register writes, checked %0d word beats",
             samples_sent, writes_done, words_checked);
    $display("blocks of 1 to 16 samples, sections of 1 to 4096 blocks, flat and clamped blocks");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
